// ===== design/lebcs_pkg.sv =====
// ----------------------------------------------------------------------------
// LED blink code package
// Shared types, command codes and register indexes of the blink sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package lebcs_pkg;

    localparam int TICK_W  = 16;
    localparam int COUNT_W = 4;
    localparam int INDEX_W = 3;

    localparam logic [1:0] CMD_TICK = 2'd0;
    localparam logic [1:0] CMD_SHOW = 2'd1;
    localparam logic [1:0] CMD_STOP = 2'd2;
    localparam logic [1:0] CMD_NONE = 2'd3;

    localparam logic [1:0] KIND_NONE   = 2'd0;
    localparam logic [1:0] KIND_LINK   = 2'd1;
    localparam logic [1:0] KIND_MASTER = 2'd2;
    localparam logic [1:0] KIND_TEMP   = 2'd3;

    localparam logic [INDEX_W-1:0] REG_ON_TICKS     = 3'd0;
    localparam logic [INDEX_W-1:0] REG_OFF_TICKS    = 3'd1;
    localparam logic [INDEX_W-1:0] REG_WAIT_TICKS   = 3'd2;
    localparam logic [INDEX_W-1:0] REG_COUNT_LINK   = 3'd3;
    localparam logic [INDEX_W-1:0] REG_COUNT_MASTER = 3'd4;
    localparam logic [INDEX_W-1:0] REG_COUNT_TEMP   = 3'd5;

    localparam logic [TICK_W-1:0]  RST_ON_TICKS     = 16'd30;
    localparam logic [TICK_W-1:0]  RST_OFF_TICKS    = 16'd30;
    localparam logic [TICK_W-1:0]  RST_WAIT_TICKS   = 16'd170;
    localparam logic [COUNT_W-1:0] RST_COUNT_LINK   = 4'd2;
    localparam logic [COUNT_W-1:0] RST_COUNT_MASTER = 4'd3;
    localparam logic [COUNT_W-1:0] RST_COUNT_TEMP   = 4'd4;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_LIT  = 2'd1,
        PH_DARK = 2'd2,
        PH_WAIT = 2'd3
    } phase_t;

    typedef struct packed {
        logic [TICK_W-1:0]  on_ticks;
        logic [TICK_W-1:0]  off_ticks;
        logic [TICK_W-1:0]  wait_ticks;
        logic [COUNT_W-1:0] count_link;
        logic [COUNT_W-1:0] count_master;
        logic [COUNT_W-1:0] count_temp;
    } cfg_t;

    typedef struct packed {
        logic active;
        logic led;
    } stat_t;

endpackage

`default_nettype wire

// ===== design/lebcs_cfg.sv =====
// ----------------------------------------------------------------------------
// LED blink code configuration registers
// Holds the timing and pulse count registers written through the config port.
// ----------------------------------------------------------------------------
`default_nettype none

module lebcs_cfg (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          wr_en,
    input  wire logic [lebcs_pkg::INDEX_W-1:0] wr_index,
    input  wire logic [lebcs_pkg::TICK_W-1:0]  wr_data,
    output lebcs_pkg::cfg_t                    cfg
);
    import lebcs_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            unique case (wr_index)
                REG_ON_TICKS:     cfg_next.on_ticks     = wr_data;
                REG_OFF_TICKS:    cfg_next.off_ticks    = wr_data;
                REG_WAIT_TICKS:   cfg_next.wait_ticks   = wr_data;
                REG_COUNT_LINK:   cfg_next.count_link   = wr_data[COUNT_W-1:0];
                REG_COUNT_MASTER: cfg_next.count_master = wr_data[COUNT_W-1:0];
                REG_COUNT_TEMP:   cfg_next.count_temp   = wr_data[COUNT_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.on_ticks     <= RST_ON_TICKS;
            cfg_reg.off_ticks    <= RST_OFF_TICKS;
            cfg_reg.wait_ticks   <= RST_WAIT_TICKS;
            cfg_reg.count_link   <= RST_COUNT_LINK;
            cfg_reg.count_master <= RST_COUNT_MASTER;
            cfg_reg.count_temp   <= RST_COUNT_TEMP;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

// ===== design/lebcs_core.sv =====
// ----------------------------------------------------------------------------
// LED blink code sequencer core
// Phase state machine, phase timer and pulse counters, one item per cycle while adv is set.
// ----------------------------------------------------------------------------
`default_nettype none

module lebcs_core (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            adv,
    input  wire logic [1:0]      cmd,
    input  wire logic [1:0]      kind,
    input  wire lebcs_pkg::cfg_t cfg,
    output lebcs_pkg::stat_t     cur,
    output lebcs_pkg::stat_t     nxt
);
    import lebcs_pkg::*;

    phase_t               phase_reg, phase_next;
    logic                 led_reg, led_next;
    logic [TICK_W-1:0]    ticks_reg, ticks_next;
    logic [COUNT_W-1:0]   pulses_reg, pulses_next;
    logic [COUNT_W-1:0]   count_reg, count_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_IDLE;
            led_reg    <= 1'b0;
            ticks_reg  <= '0;
            pulses_reg <= '0;
            count_reg  <= '0;
        end else if (adv) begin
            phase_reg  <= phase_next;
            led_reg    <= led_next;
            ticks_reg  <= ticks_next;
            pulses_reg <= pulses_next;
            count_reg  <= count_next;
        end
    end

    always_comb begin
        logic [COUNT_W-1:0] sel_cnt;
        logic [COUNT_W-1:0] dec_pulses;

        phase_next  = phase_reg;
        led_next    = led_reg;
        ticks_next  = ticks_reg;
        pulses_next = pulses_reg;
        count_next  = count_reg;

        unique case (kind)
            KIND_LINK:   sel_cnt = cfg.count_link;
            KIND_MASTER: sel_cnt = cfg.count_master;
            KIND_TEMP:   sel_cnt = cfg.count_temp;
            default:     sel_cnt = '0;
        endcase

        dec_pulses = (pulses_reg != '0) ? pulses_reg - 1'b1 : '0;

        unique case (cmd)
            CMD_TICK: begin
                if (phase_reg != PH_IDLE) begin
                    if (ticks_reg <= 16'd1) begin
                        unique case (phase_reg)
                            PH_LIT: begin
                                led_next   = 1'b0;
                                phase_next = PH_DARK;
                                ticks_next = cfg.off_ticks;
                            end
                            PH_DARK: begin
                                pulses_next = dec_pulses;
                                if (dec_pulses != '0) begin
                                    led_next   = 1'b1;
                                    phase_next = PH_LIT;
                                    ticks_next = cfg.on_ticks;
                                end else begin
                                    phase_next = PH_WAIT;
                                    ticks_next = cfg.wait_ticks;
                                end
                            end
                            PH_WAIT: begin
                                pulses_next = count_reg;
                                led_next    = 1'b1;
                                phase_next  = PH_LIT;
                                ticks_next  = cfg.on_ticks;
                            end
                            default: ticks_next = '0;
                        endcase
                    end else begin
                        ticks_next = ticks_reg - 1'b1;
                    end
                end
            end
            CMD_SHOW: begin
                if (sel_cnt == '0) begin
                    phase_next  = PH_IDLE;
                    ticks_next  = '0;
                    pulses_next = '0;
                    count_next  = '0;
                end else if (!(sel_cnt == count_reg && phase_reg != PH_IDLE)) begin
                    count_next  = sel_cnt;
                    pulses_next = sel_cnt;
                    led_next    = 1'b1;
                    phase_next  = PH_LIT;
                    ticks_next  = cfg.on_ticks;
                end
            end
            CMD_STOP: begin
                phase_next  = PH_IDLE;
                ticks_next  = '0;
                pulses_next = '0;
                count_next  = '0;
            end
            default: ;
        endcase
    end

    assign cur.led    = led_reg;
    assign cur.active = (phase_reg != PH_IDLE);
    assign nxt.led    = led_next;
    assign nxt.active = (phase_next != PH_IDLE);

endmodule

`default_nettype wire

// ===== design/led_error_blink_code_sequencer.sv =====
// ----------------------------------------------------------------------------
// LED error blink code sequencer
// Turns tick, show and stop items into an error LED blink code stream.
// Throughput: one item per cycle unless the result stream stalls; the input
// register and the result register each hold one item, and an item passes
// through the input register and then the result register.
// Reset: synchronous, active low; the LED is dark, the sequence idle and the
// configuration registers return to their default timing and counts.
// ----------------------------------------------------------------------------
`default_nettype none

module led_error_blink_code_sequencer (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_tvalid,
    output      logic                          s_tready,
    input  wire logic [7:0]                    s_tdata,   // [1:0] error_kind
    input  wire logic [1:0]                    s_tuser,   // [1:0] cmd
    output      logic                          m_tvalid,
    input  wire logic                          m_tready,
    output      logic [7:0]                    m_tdata,   // [0] led_on, [1] active
    input  wire logic                          cfg_valid,
    output      logic                          cfg_ready,
    input  wire logic [lebcs_pkg::INDEX_W-1:0] cfg_index,
    input  wire logic [lebcs_pkg::TICK_W-1:0]  cfg_data
);
    import lebcs_pkg::*;

    cfg_t        cfg;
    stat_t       cur;
    stat_t       nxt;
    logic        in_valid_reg;
    logic [1:0]  in_cmd_reg;
    logic [1:0]  in_kind_reg;
    logic        m_valid_reg;
    stat_t       m_data_reg;
    logic        adv;

    assign cfg_ready = 1'b1;

    lebcs_cfg u_cfg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_en    (cfg_valid),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    assign adv      = in_valid_reg && (!m_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || adv;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_cmd_reg  <= s_tuser;
            in_kind_reg <= s_tdata[1:0];
        end
    end

    lebcs_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .adv     (adv),
        .cmd     (in_cmd_reg),
        .kind    (in_kind_reg),
        .cfg     (cfg),
        .cur     (cur),
        .nxt     (nxt)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (!m_valid_reg || m_tready) begin
            m_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            m_data_reg <= nxt;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {6'd0, m_data_reg.active, m_data_reg.led};

    a_stop_idles: assert property (@(posedge aclk) disable iff (!aresetn)
        adv && in_cmd_reg == CMD_STOP |=> m_tvalid && !m_tdata[1])
        else $error("active still set after a stop item");

    a_stop_keeps_led: assert property (@(posedge aclk) disable iff (!aresetn)
        adv && in_cmd_reg == CMD_STOP |=> m_tdata[0] == $past(cur.led))
        else $error("LED level changed by a stop item");

    a_none_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        adv && in_cmd_reg == CMD_NONE |=>
            m_tdata[0] == $past(cur.led) && m_tdata[1] == $past(cur.active))
        else $error("unused command changed the sequencer state");

    a_show_lights: assert property (@(posedge aclk) disable iff (!aresetn)
        adv && in_cmd_reg == CMD_SHOW && !cur.active && nxt.active |=> m_tdata[0])
        else $error("new blink code did not start with a lit pulse");

endmodule

`default_nettype wire

// ===== dv/led_error_blink_code_sequencer_test.sv =====
// ----------------------------------------------------------------------------
// LED error blink code sequencer test
// Drives tick, show and stop items into the sequencer while the configuration
// is switched between default, minimum, zero and maximum timings and counts.
// A scoreboard predicts the LED level and the active flag of every item and
// compares them with the result stream. Both sides stall at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module led_error_blink_code_sequencer_test;

    import lebcs_pkg::*;

    class blink_scoreboard;
        logic [TICK_W-1:0]  on_len;
        logic [TICK_W-1:0]  off_len;
        logic [TICK_W-1:0]  wait_len;
        logic [COUNT_W-1:0] kind_count [4];
        logic               led;
        phase_t             ph;
        logic [TICK_W-1:0]  ticks_to_go;
        logic [COUNT_W-1:0] pulses_left;
        logic [COUNT_W-1:0] pulse_count;
        stat_t              pending [$];
        int                 taken;
        int                 errors;

        function new();
            on_len = RST_ON_TICKS;
            off_len = RST_OFF_TICKS;
            wait_len = RST_WAIT_TICKS;
            kind_count[KIND_NONE] = '0;
            kind_count[KIND_LINK] = RST_COUNT_LINK;
            kind_count[KIND_MASTER] = RST_COUNT_MASTER;
            kind_count[KIND_TEMP] = RST_COUNT_TEMP;
            led = 1'b0;
            ph = PH_IDLE;
            ticks_to_go = '0;
            pulses_left = '0;
            pulse_count = '0;
            taken = 0;
            errors = 0;
        endfunction

        function void write_register(input logic [INDEX_W-1:0] idx,
                                     input logic [TICK_W-1:0] val);
            case (idx)
                REG_ON_TICKS:     on_len = val;
                REG_OFF_TICKS:    off_len = val;
                REG_WAIT_TICKS:   wait_len = val;
                REG_COUNT_LINK:   kind_count[KIND_LINK] = val[COUNT_W-1:0];
                REG_COUNT_MASTER: kind_count[KIND_MASTER] = val[COUNT_W-1:0];
                REG_COUNT_TEMP:   kind_count[KIND_TEMP] = val[COUNT_W-1:0];
                default: ;
            endcase
        endfunction

        function void light();
            led = 1'b1;
            ph = PH_LIT;
            ticks_to_go = on_len;
        endfunction

        function void halt();
            ph = PH_IDLE;
            ticks_to_go = '0;
            pulses_left = '0;
            pulse_count = '0;
        endfunction

        function void note_item(input logic [1:0] cmd, input logic [1:0] kind);
            logic [COUNT_W-1:0] cnt;
            stat_t              s;
            taken++;
            case (cmd)
                CMD_TICK: begin
                    if (ph != PH_IDLE) begin
                        if (ticks_to_go <= 1) begin
                            ticks_to_go = '0;
                            case (ph)
                                PH_LIT: begin
                                    led = 1'b0;
                                    ph = PH_DARK;
                                    ticks_to_go = off_len;
                                end
                                PH_DARK: begin
                                    if (pulses_left != 0) pulses_left--;
                                    if (pulses_left != 0) begin
                                        light();
                                    end else begin
                                        ph = PH_WAIT;
                                        ticks_to_go = wait_len;
                                    end
                                end
                                PH_WAIT: begin
                                    pulses_left = pulse_count;
                                    light();
                                end
                                default: ;
                            endcase
                        end else begin
                            ticks_to_go--;
                        end
                    end
                end
                CMD_SHOW: begin
                    cnt = kind_count[kind];
                    if (cnt == 0) begin
                        halt();
                    end else if (!(cnt == pulse_count && ph != PH_IDLE)) begin
                        halt();
                        pulse_count = cnt;
                        pulses_left = cnt;
                        light();
                    end
                end
                CMD_STOP: halt();
                default: ;
            endcase
            s.led = led;
            s.active = (ph != PH_IDLE);
            pending.push_back(s);
        endfunction

        function void check_result(input logic [7:0] data);
            stat_t want;
            if (pending.size() == 0) begin
                $display("%0t: result %h arrived with nothing expected", $time, data);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (data[0] !== want.led) begin
                $display("%0t: led_on expected %0b actual %0b", $time, want.led, data[0]);
                errors++;
            end
            if (data[1] !== want.active) begin
                $display("%0t: active expected %0b actual %0b", $time, want.active, data[1]);
                errors++;
            end
        endfunction
    endclass

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [7:0]          s_tdata = '0;    // [1:0] error_kind
    logic [1:0]          s_tuser = '0;    // [1:0] cmd
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [7:0]          m_tdata;         // [0] led_on, [1] active
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [INDEX_W-1:0]  cfg_index = '0;
    logic [TICK_W-1:0]   cfg_data = '0;
    logic                steady = 1'b0;

    blink_scoreboard book = new();

    led_error_blink_code_sequencer i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    task automatic send_item(input logic [1:0] cmd, input logic [1:0] kind);
        int gap;
        if (!steady && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 14);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= cmd;
        s_tdata <= {6'b0, kind};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        book.note_item(cmd, kind);
    endtask

    task automatic random_items(input int n);
        int         r;
        logic [1:0] cmd;
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(0, 99);
            if (r < 84) cmd = CMD_TICK;
            else if (r < 93) cmd = CMD_SHOW;
            else if (r < 96) cmd = CMD_STOP;
            else cmd = CMD_NONE;
            send_item(cmd, 2'($urandom_range(0, 3)));
        end
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (book.pending.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [INDEX_W-1:0] idx, input logic [TICK_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        book.write_register(idx, val);
    endtask

    task automatic configure(input logic [TICK_W-1:0] on_v, off_v, wait_v, c_link,
                             c_master, c_temp);
        drain();
        write_reg(REG_ON_TICKS, on_v);
        write_reg(REG_OFF_TICKS, off_v);
        write_reg(REG_WAIT_TICKS, wait_v);
        write_reg(REG_COUNT_LINK, c_link);
        write_reg(REG_COUNT_MASTER, c_master);
        write_reg(REG_COUNT_TEMP, c_temp);
        cfg_valid <= 1'b0;
    endtask

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Idle ticks, the unused command and kind none while idle, then
        // repeated and new shows, a frozen stop and a stop by kind none.
        send_item(CMD_TICK, KIND_TEMP);
        send_item(CMD_NONE, KIND_NONE);
        send_item(CMD_SHOW, KIND_NONE);
        send_item(CMD_SHOW, KIND_LINK);
        send_item(CMD_SHOW, KIND_LINK);
        send_item(CMD_TICK, KIND_NONE);
        send_item(CMD_TICK, KIND_MASTER);
        send_item(CMD_NONE, KIND_TEMP);
        send_item(CMD_SHOW, KIND_MASTER);
        send_item(CMD_TICK, KIND_LINK);
        send_item(CMD_STOP, KIND_NONE);
        send_item(CMD_TICK, KIND_NONE);
        send_item(CMD_SHOW, KIND_TEMP);
        send_item(CMD_SHOW, KIND_TEMP);
        send_item(CMD_TICK, KIND_TEMP);
        send_item(CMD_SHOW, KIND_NONE);
        send_item(CMD_STOP, KIND_TEMP);
        send_item(CMD_SHOW, KIND_MASTER);
        send_item(CMD_STOP, KIND_MASTER);

        configure(16'd1, 16'd1, 16'd1, 16'd1, 16'd15, 16'd0);
        random_items(400);
        configure(16'd0, 16'd2, 16'd0, 16'd15, 16'd1, 16'd7);
        random_items(400);
        configure(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0003, 16'hFFF2);
        random_items(150);
        configure(16'($urandom_range(1, 5)), 16'($urandom_range(1, 5)),
                  16'($urandom_range(1, 8)), 16'($urandom_range(0, 15)),
                  16'($urandom_range(0, 15)), 16'($urandom_range(0, 15)));
        steady = 1'b1;
        random_items(580);
        drain();

        if (book.errors == 0 && book.pending.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    // The receiver stalls in random bursts and once holds off long enough
    // for the block to fill up and stop taking items.
    initial begin
        int stall_left;
        int hold_left;
        bit pressed;
        stall_left = 0;
        hold_left = 0;
        pressed = 1'b0;
        while (!aresetn) @(posedge aclk);
        forever begin
            @(posedge aclk);
            if (m_tvalid === 1'b1 && m_tready) book.check_result(m_tdata);
            if (!pressed && book.taken >= 50) begin
                pressed = 1'b1;
                hold_left = 100;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else if (!steady && $urandom_range(0, 7) == 0) begin
                stall_left = $urandom_range(0, 13);
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    initial begin
        #(5_000_000);
        $display("CHECK FAILED");
        $finish;
    end

endmodule

// ===== files.f =====
design/lebcs_pkg.sv
design/lebcs_cfg.sv
design/lebcs_core.sv
design/led_error_blink_code_sequencer.sv
dv/led_error_blink_code_sequencer_test.sv
